// ----- hw/rtl/imufds_pkg.sv -----
package imufds_pkg;

	// Frame layout
	localparam int FRAME_LEN = 20;
	localparam int FILL_W = 5;
	localparam logic [7:0] TRAILER_NL = 8'h0A;
	localparam logic [7:0] TRAILER_NUL = 8'h00;

	// Byte offsets inside a frame
	localparam int ACC_POS = 2;
	localparam int GYR_POS = 8;
	localparam int MAJOR_POS = 14;
	localparam int MINOR_POS = 16;

	// Configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_EPOCH_OFFSET = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN = 8'd2;

	// Register reset values
	localparam logic [31:0] EPOCH_OFFSET_RST = 32'd1678364100;
	localparam logic [23:0] ACCEL_GAIN_RST = 24'd5141509;
	localparam logic [23:0] GYRO_GAIN_RST = 24'd4575276;

	// Minor tick to nanoseconds: minor * 50000 / 3, divide by 3 as reciprocal
	localparam logic [15:0] NS_PER_TICK_X3 = 16'd50000;
	localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;
	localparam int RECIP3_SHIFT = 33;

	// Default depth of the frame queue
	localparam int FIFO_DEPTH_DEF = 2;

	localparam int OUT_DATA_W = 208;

	// Raw fields of one frame, handed from the deframer to the scaler
	typedef struct packed {
		logic signed [15:0] acc_x;
		logic signed [15:0] acc_y;
		logic signed [15:0] acc_z;
		logic signed [15:0] gyr_x;
		logic signed [15:0] gyr_y;
		logic signed [15:0] gyr_z;
		logic [15:0] major;
		logic [15:0] minor;
	} raw_frame_t;

	// Configuration seen by the scaler
	typedef struct packed {
		logic [31:0] epoch_offset;
		logic [23:0] accel_gain;
		logic [23:0] gyro_gain;
	} cfg_t;

endpackage

// ----- hw/rtl/imufds_front.sv -----
module imufds_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [7:0]               in_byte,
	input  logic                     q_full,
	output logic                     in_ready,
	output logic                     push,
	output imufds_pkg::raw_frame_t   push_data
);

	localparam int LAST = imufds_pkg::FRAME_LEN - 1;

	logic [7:0] win_q [imufds_pkg::FRAME_LEN];
	logic [imufds_pkg::FILL_W-1:0] fill_q;
	logic accept;
	logic hit;
	logic [7:0] frame_b [imufds_pkg::FRAME_LEN];

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	// Window as it stands once this byte is in: newest byte last
	always_comb begin
		for (int i = 0; i < LAST; i++) begin
			frame_b[i] = win_q[i+1];
		end
		frame_b[LAST] = in_byte;
	end

	// Full window with the newline, nul trailer
	assign hit = accept && (fill_q == imufds_pkg::FILL_W'(LAST))
		&& (win_q[LAST] == imufds_pkg::TRAILER_NL)
		&& (in_byte == imufds_pkg::TRAILER_NUL);

	// Byte shift line
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < LAST; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[LAST] <= in_byte;
		end
	end

	// Fill count saturates one short of a frame; a hit empties the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (hit) begin
				fill_q <= '0;
			end else if (fill_q != imufds_pkg::FILL_W'(LAST)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Field extraction: words big-endian, counters little-endian
	assign push = hit;
	assign push_data.acc_x = {frame_b[imufds_pkg::ACC_POS], frame_b[imufds_pkg::ACC_POS+1]};
	assign push_data.acc_y = {frame_b[imufds_pkg::ACC_POS+2], frame_b[imufds_pkg::ACC_POS+3]};
	assign push_data.acc_z = {frame_b[imufds_pkg::ACC_POS+4], frame_b[imufds_pkg::ACC_POS+5]};
	assign push_data.gyr_x = {frame_b[imufds_pkg::GYR_POS], frame_b[imufds_pkg::GYR_POS+1]};
	assign push_data.gyr_y = {frame_b[imufds_pkg::GYR_POS+2], frame_b[imufds_pkg::GYR_POS+3]};
	assign push_data.gyr_z = {frame_b[imufds_pkg::GYR_POS+4], frame_b[imufds_pkg::GYR_POS+5]};
	assign push_data.major = {frame_b[imufds_pkg::MAJOR_POS+1], frame_b[imufds_pkg::MAJOR_POS]};
	assign push_data.minor = {frame_b[imufds_pkg::MINOR_POS+1], frame_b[imufds_pkg::MINOR_POS]};

endmodule

// ----- hw/rtl/imufds_fifo.sv -----
module imufds_fifo #(
	parameter int DEPTH = imufds_pkg::FIFO_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  imufds_pkg::raw_frame_t   push_data,
	output logic                     full,
	input  logic                     pop,
	output imufds_pkg::raw_frame_t   pop_data,
	output logic                     empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	imufds_pkg::raw_frame_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/imufds_back.sv -----
module imufds_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  imufds_pkg::cfg_t                      cfg,
	input  logic                                  in_valid,
	input  imufds_pkg::raw_frame_t                in_data,
	output logic                                  in_ready,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [imufds_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	logic v_s1;
	logic v_s2;
	logic rdy_s1;
	logic rdy_s2;

	logic signed [39:0] prod_s1 [6];
	logic [31:0] sec_s1;
	logic [31:0] ns_x3_s1;

	logic signed [23:0] scl_s2 [6];
	logic [31:0] sec_s2;
	logic [30:0] ns_s2;

	logic signed [15:0] raw [6];
	logic signed [24:0] gain [6];
	logic [63:0] ns_full;

	// Elastic handshake between stages
	assign rdy_s2 = !v_s2 || m_axis_tready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Lane operands
	always_comb begin
		raw[0] = in_data.acc_x;
		raw[1] = in_data.acc_y;
		raw[2] = in_data.acc_z;
		raw[3] = in_data.gyr_x;
		raw[4] = in_data.gyr_y;
		raw[5] = in_data.gyr_z;
		for (int i = 0; i < 3; i++) begin
			gain[i] = {1'b0, cfg.accel_gain};
			gain[i+3] = {1'b0, cfg.gyro_gain};
		end
	end

	// Stage 1: raw times gain, seconds sum, minor times 50000
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			for (int i = 0; i < 6; i++) begin
				prod_s1[i] <= raw[i] * gain[i];
			end
			sec_s1 <= 32'(in_data.major) + cfg.epoch_offset;
			ns_x3_s1 <= 32'(in_data.minor) * 32'(imufds_pkg::NS_PER_TICK_X3);
		end
	end

	// Divide by 3 through the reciprocal
	assign ns_full = 64'(ns_x3_s1) * 64'(imufds_pkg::RECIP3);

	// Stage 2: floor shift by 16, nanoseconds
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			for (int i = 0; i < 6; i++) begin
				scl_s2[i] <= prod_s1[i][39:16];
			end
			sec_s2 <= sec_s1;
			ns_s2 <= ns_full[imufds_pkg::RECIP3_SHIFT +: 31];
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata = {1'b0, ns_s2, sec_s2, scl_s2[5], scl_s2[4], scl_s2[3],
		scl_s2[2], scl_s2[1], scl_s2[0]};

endmodule

// ----- hw/rtl/imu_frame_deframer_scaler.sv -----
// IMU frame deframer and scaler.
// s_axis carries one received serial byte per request (tdata[7:0]). The block
// keeps the last 20 bytes; when they end in newline, nul it pulls out three
// accelerometer and three gyroscope words, scales them by the programmed
// gains into 2^-16 units, and forms the timestamp from the two counters.
// m_axis carries one result per frame found; other bytes give no result.
// cfg is a write port (cfg_valid, cfg_ready, cfg_index, cfg_data); it is
// always ready: index 0 epoch offset, 1 accel gain, 2 gyro gain, others
// ignored. Write it only while no frame is in flight.
// Throughput: one byte per cycle while the frame queue is not full. The
// byte window shift and trailer check happen in the same cycle as the byte
// is accepted; the scaler is a two-stage pipeline (multiply, then shift and
// reciprocal divide by 3) that takes one frame per cycle unless m_axis stalls.
// A found frame passes the queue write, then stage 1, then stage 2.
// Reset empties the window, queue and pipeline and loads the register
// defaults. When m_axis stalls, results back up into the frame queue;
// s_axis tready drops only while that queue is full.
module imu_frame_deframer_scaler #(
	parameter int FIFO_DEPTH = imufds_pkg::FIFO_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// tdata: rx_byte[7:0]
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [7:0]                            s_axis_tdata,
	// tdata: accel_x[23:0], accel_y[47:24], accel_z[71:48], rate_x[95:72],
	// rate_y[119:96], rate_z[143:120], stamp_seconds[175:144],
	// stamp_nanoseconds[206:176], zero pad[207]
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [imufds_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [imufds_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                           cfg_data
);

	imufds_pkg::cfg_t cfg_q;
	imufds_pkg::raw_frame_t push_data;
	imufds_pkg::raw_frame_t pop_data;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.epoch_offset <= imufds_pkg::EPOCH_OFFSET_RST;
			cfg_q.accel_gain <= imufds_pkg::ACCEL_GAIN_RST;
			cfg_q.gyro_gain <= imufds_pkg::GYRO_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				imufds_pkg::REG_EPOCH_OFFSET: cfg_q.epoch_offset <= cfg_data;
				imufds_pkg::REG_ACCEL_GAIN: cfg_q.accel_gain <= cfg_data[23:0];
				imufds_pkg::REG_GYRO_GAIN: cfg_q.gyro_gain <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	imufds_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_byte   (s_axis_tdata),
		.q_full    (q_full),
		.in_ready  (s_axis_tready),
		.push      (push),
		.push_data (push_data)
	);

	imufds_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	imufds_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (!q_empty),
		.in_data       (pop_data),
		.in_ready      (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
